/* rtl/core/bsal_pkg.sv */
// Shared package for the blade station aero loads block.
// Holds field widths, pipeline depths, register codes, the arctangent table
// and the configuration type. Depends on nothing.
`default_nettype none

package bsal_pkg;

    // field widths
    localparam int SPEED_W   = 32;
    localparam int ANGLE_W   = 32;
    localparam int COEFF_W   = 16;
    localparam int CMAG_W    = 32;
    localparam int LOAD_W    = 48;
    localparam int VSQ_W     = 64;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int RHO_W      = 20;
    localparam int SOUND_W    = 32;
    localparam int CHORD_W    = 24;
    localparam int AREA_W     = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AIR_DENSITY    = 2'd0,
        CFG_SOUND_SPEED    = 2'd1,
        CFG_CHORD_LENGTH   = 2'd2,
        CFG_REFERENCE_AREA = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [RHO_W-1:0]   air_density;
        logic [SOUND_W-1:0] sound_speed;
        logic [CHORD_W-1:0] chord_length;
        logic [AREA_W-1:0]  reference_area;
    } cfg_t;

    localparam logic [RHO_W-1:0]   RHO_RESET   = 20'd80282;
    localparam logic [SOUND_W-1:0] SOUND_RESET = 32'd22478848;
    localparam logic [CHORD_W-1:0] CHORD_RESET = 24'd65536;
    localparam logic [AREA_W-1:0]  AREA_RESET  = 32'd65536;

    // CORDIC
    localparam int CORDIC_STEPS = 28;
    localparam int CORDIC_W     = 56;
    localparam int CORDIC_PRE   = 20;
    localparam logic signed [ANGLE_W-1:0] HALF_PI = 32'sd421657428;

    // atan(2^-i), Q3.28, rounded to nearest
    localparam logic signed [ANGLE_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
        32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
        32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
        32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
        32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
        32'sd256,       32'sd128,       32'sd64,       32'sd32,
        32'sd16,        32'sd8,         32'sd4,        32'sd2
    };

    // square root and Mach divider
    localparam int ROOT_STEPS = 32;
    localparam int QUO_BITS   = 32;
    localparam int MACH_FRAC  = 24;
    localparam int REM_W      = CMAG_W + MACH_FRAC;

    // pipeline depths, in stages after acceptance
    localparam int CORDIC_DEPTH = CORDIC_STEPS + 2;
    localparam int MAG_DEPTH    = 2 + ROOT_STEPS + 1 + QUO_BITS;
    localparam int DEPTH        = MAG_DEPTH;
    localparam int MAC_STEPS    = 6;
    localparam int LOAD_DEPTH   = 3 + MAC_STEPS + 1;
    localparam int CORDIC_PAD   = DEPTH - CORDIC_DEPTH;
    localparam int LOAD_PAD     = DEPTH - LOAD_DEPTH;

    // load datapath
    localparam int LANES        = 3;
    localparam int LANE_LIFT    = 0;
    localparam int LANE_DRAG    = 1;
    localparam int LANE_MOMENT  = 2;
    localparam int X_W          = 96;
    localparam int ACC_W        = 160;
    localparam int FORCE_SHIFT  = 61;
    localparam int MOMENT_SHIFT = 77;

endpackage

`default_nettype wire

/* rtl/core/bsal_in_if.sv */
// Request channel of the blade station aero loads block.
// Valid/ready handshake with the station inputs; uses bsal_pkg.
`default_nettype none

interface bsal_in_if import bsal_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SPEED_W-1:0]  tangent_speed;
    logic signed [SPEED_W-1:0]  normal_speed;
    logic signed [ANGLE_W-1:0]  pitch_angle;
    logic signed [COEFF_W-1:0]  lift_coeff;
    logic signed [COEFF_W-1:0]  drag_coeff;
    logic signed [COEFF_W-1:0]  moment_coeff;

    modport source (
        output valid, tangent_speed, normal_speed, pitch_angle,
               lift_coeff, drag_coeff, moment_coeff,
        input  ready
    );
    modport sink (
        input  valid, tangent_speed, normal_speed, pitch_angle,
               lift_coeff, drag_coeff, moment_coeff,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/bsal_out_if.sv */
// Result channel of the blade station aero loads block.
// Valid/ready handshake with the angles, speeds and loads; uses bsal_pkg.
`default_nettype none

interface bsal_out_if import bsal_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [ANGLE_W-1:0]  inflow_angle;
    logic signed [ANGLE_W-1:0]  attack_angle;
    logic                       reverse_flow;
    logic [CMAG_W-1:0]          speed_magnitude;
    logic [CMAG_W-1:0]          mach_number;
    logic signed [LOAD_W-1:0]   lift_force;
    logic signed [LOAD_W-1:0]   drag_force;
    logic signed [LOAD_W-1:0]   pitch_moment;

    modport source (
        output valid, inflow_angle, attack_angle, reverse_flow, speed_magnitude,
               mach_number, lift_force, drag_force, pitch_moment,
        input  ready
    );
    modport sink (
        input  valid, inflow_angle, attack_angle, reverse_flow, speed_magnitude,
               mach_number, lift_force, drag_force, pitch_moment,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/blade_station_aero_loads.sv */
// Blade station aero loads: inflow angle, angle of attack, speed, Mach, lift, drag, moment.
// Pipe depth from request to result is set by the 32-stage square root followed by
// the 32-stage Mach divider. Throughput: one request per cycle; the whole pipe holds
// while a finished result is not taken. Reset (rst_n, async, active low) clears all
// valid bits and loads the register defaults; data registers are not reset.
`default_nettype none

module blade_station_aero_loads import bsal_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    bsal_in_if.sink               item,
    bsal_out_if.source            result
);

    // ------------------------------------------------------------------
    // Configuration registers. To be written only while the pipe is empty, which
    // the block itself does not enforce; so every stage reads them directly.
    // ------------------------------------------------------------------
    cfg_t cfg_reg, cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_AIR_DENSITY:    cfg_next.air_density    = cfg_wr_data[RHO_W-1:0];
                CFG_SOUND_SPEED:    cfg_next.sound_speed    = cfg_wr_data[SOUND_W-1:0];
                CFG_CHORD_LENGTH:   cfg_next.chord_length   = cfg_wr_data[CHORD_W-1:0];
                CFG_REFERENCE_AREA: cfg_next.reference_area = cfg_wr_data[AREA_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.air_density    <= RHO_RESET;
            cfg_reg.sound_speed    <= SOUND_RESET;
            cfg_reg.chord_length   <= CHORD_RESET;
            cfg_reg.reference_area <= AREA_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipe control: valid bits travel with the data. All stages advance
    // together unless the output holds a result that is not taken.
    // ------------------------------------------------------------------
    logic [DEPTH-1:0] vld_reg;
    logic             advance;

    assign advance    = !vld_reg[DEPTH-1] || result.ready;
    assign item.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= {vld_reg[DEPTH-2:0], item.valid};
    end

    // ------------------------------------------------------------------
    // Angles (30 stages) and speed / Mach (67 stages)
    // ------------------------------------------------------------------
    logic signed [ANGLE_W-1:0] phi_c, aoa_c;
    logic                      rev_c;
    logic [VSQ_W-1:0]          vsq_s2;
    logic [CMAG_W-1:0]         mag_out, mach_out;

    bsal_cordic u_cordic (
        .clk           (clk),
        .en            (advance),
        .tangent_speed (item.tangent_speed),
        .normal_speed  (item.normal_speed),
        .pitch_angle   (item.pitch_angle),
        .inflow_angle  (phi_c),
        .attack_angle  (aoa_c),
        .reverse_flow  (rev_c)
    );

    bsal_magnitude u_mag (
        .clk             (clk),
        .en              (advance),
        .tangent_speed   (item.tangent_speed),
        .normal_speed    (item.normal_speed),
        .sound_speed     (cfg_reg.sound_speed),
        .vsq             (vsq_s2),
        .speed_magnitude (mag_out),
        .mach_number     (mach_out)
    );

    // ------------------------------------------------------------------
    // Loads: |C| * rho * S [* chord] * v^2, then shift, saturate, sign.
    //   s1: rho*S, coefficient magnitudes
    //   s2: |Cl|*rho*S, |Cd|*rho*S, rho*S*chord
    //   s3: |Cm|*rho*S*chord, v^2 picked up from the magnitude unit
    //   s4..s9: six 32x32 partial products against v^2, accumulated
    //   s10: truncation and saturation to 48 bits
    // ------------------------------------------------------------------
    logic signed [COEFF_W-1:0] coeff_in [LANES];
    logic [LANES-1:0]          neg_s1_reg, neg_s2_reg, neg_s3_reg;
    logic [COEFF_W-1:0]        cmag_s1_reg [LANES];
    logic [51:0]               kr_s1_reg;
    logic [67:0]               xl_s2_reg, xd_s2_reg;
    logic [75:0]               kc_s2_reg;
    logic [COEFF_W-1:0]        am_s2_reg;
    logic [X_W-1:0]            x_s3_reg [LANES];
    logic [VSQ_W-1:0]          vsq_s3_reg;

    logic [ACC_W-1:0]          acc_reg  [MAC_STEPS][LANES];
    logic [X_W-1:0]            macx_reg [MAC_STEPS][LANES];
    logic [VSQ_W-1:0]          macv_reg [MAC_STEPS];
    logic [LANES-1:0]          macn_reg [MAC_STEPS];

    logic signed [LOAD_W-1:0]  load_reg [LANES];

    assign coeff_in[LANE_LIFT]   = item.lift_coeff;
    assign coeff_in[LANE_DRAG]   = item.drag_coeff;
    assign coeff_in[LANE_MOMENT] = item.moment_coeff;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            kr_s1_reg <= cfg_reg.air_density * cfg_reg.reference_area;
            for (int l = 0; l < LANES; l++)
            begin
                neg_s1_reg[l]  <= coeff_in[l][COEFF_W-1];
                // the most negative code maps to 0x8000, its true magnitude
                cmag_s1_reg[l] <= coeff_in[l][COEFF_W-1] ? COEFF_W'(-coeff_in[l])
                                                         : COEFF_W'(coeff_in[l]);
            end

            xl_s2_reg  <= cmag_s1_reg[LANE_LIFT] * kr_s1_reg;
            xd_s2_reg  <= cmag_s1_reg[LANE_DRAG] * kr_s1_reg;
            kc_s2_reg  <= kr_s1_reg * cfg_reg.chord_length;
            am_s2_reg  <= cmag_s1_reg[LANE_MOMENT];
            neg_s2_reg <= neg_s1_reg;

            x_s3_reg[LANE_LIFT]   <= X_W'(xl_s2_reg);
            x_s3_reg[LANE_DRAG]   <= X_W'(xd_s2_reg);
            x_s3_reg[LANE_MOMENT] <= X_W'(am_s2_reg * kc_s2_reg);
            vsq_s3_reg            <= vsq_s2;
            neg_s3_reg            <= neg_s2_reg;
        end
    end

    // partial product k uses 32-bit chunk k/2 of X and half k%2 of v^2
    for (genvar k = 0; k < MAC_STEPS; k++)
    begin : g_mac
        localparam int XI = k / 2;
        localparam int VJ = k % 2;

        logic [ACC_W-1:0] acc_in [LANES];
        logic [X_W-1:0]   x_in   [LANES];
        logic [VSQ_W-1:0] v_in;
        logic [LANES-1:0] n_in;

        if (k == 0)
        begin : g_first
            for (genvar l = 0; l < LANES; l++)
            begin : g_lane
                assign acc_in[l] = '0;
                assign x_in[l]   = x_s3_reg[l];
            end
            assign v_in = vsq_s3_reg;
            assign n_in = neg_s3_reg;
        end
        else
        begin : g_next
            for (genvar l = 0; l < LANES; l++)
            begin : g_lane
                assign acc_in[l] = acc_reg[k-1][l];
                assign x_in[l]   = macx_reg[k-1][l];
            end
            assign v_in = macv_reg[k-1];
            assign n_in = macn_reg[k-1];
        end

        for (genvar l = 0; l < LANES; l++)
        begin : g_lane_mac
            logic [63:0] part;

            assign part = x_in[l][32*XI +: 32] * v_in[32*VJ +: 32];

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    acc_reg[k][l]  <= acc_in[l] + (ACC_W'(part) << (32 * (XI + VJ)));
                    macx_reg[k][l] <= x_in[l];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                macv_reg[k] <= v_in;
                macn_reg[k] <= n_in;
            end
        end
    end

    // truncate toward zero, clamp to [-2^47, 2^47-1], then apply the sign
    for (genvar l = 0; l < LANES; l++)
    begin : g_sat
        localparam int SHIFT = (l == LANE_MOMENT) ? MOMENT_SHIFT : FORCE_SHIFT;

        logic [ACC_W-1:0]        q;
        logic                    big;
        logic signed [LOAD_W-1:0] load_next;

        assign q   = acc_reg[MAC_STEPS-1][l] >> SHIFT;
        assign big = |q[ACC_W-1:LOAD_W-1];

        always_comb
        begin
            priority if (macn_reg[MAC_STEPS-1][l])
                load_next = big ? {1'b1, {(LOAD_W-1){1'b0}}}
                                : LOAD_W'(0) - {1'b0, q[LOAD_W-2:0]};
            else
                load_next = big ? {1'b0, {(LOAD_W-1){1'b1}}}
                                : {1'b0, q[LOAD_W-2:0]};
        end

        always_ff @(posedge clk)
        begin
            if (advance)
                load_reg[l] <= load_next;
        end
    end

    // ------------------------------------------------------------------
    // Alignment lines up to the output stage
    // ------------------------------------------------------------------
    typedef struct packed {
        logic signed [ANGLE_W-1:0] phi;
        logic signed [ANGLE_W-1:0] aoa;
        logic                      rev;
    } angle_t;

    typedef struct packed {
        logic signed [LOAD_W-1:0] lift;
        logic signed [LOAD_W-1:0] drag;
        logic signed [LOAD_W-1:0] moment;
    } load_t;

    angle_t angle_pad_reg [CORDIC_PAD];
    load_t  load_pad_reg  [LOAD_PAD];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            angle_pad_reg[0].phi <= phi_c;
            angle_pad_reg[0].aoa <= aoa_c;
            angle_pad_reg[0].rev <= rev_c;
            for (int p = 1; p < CORDIC_PAD; p++)
                angle_pad_reg[p] <= angle_pad_reg[p-1];

            load_pad_reg[0].lift   <= load_reg[LANE_LIFT];
            load_pad_reg[0].drag   <= load_reg[LANE_DRAG];
            load_pad_reg[0].moment <= load_reg[LANE_MOMENT];
            for (int p = 1; p < LOAD_PAD; p++)
                load_pad_reg[p] <= load_pad_reg[p-1];
        end
    end

    // ------------------------------------------------------------------
    // Result channel
    // ------------------------------------------------------------------
    assign result.valid           = vld_reg[DEPTH-1];
    assign result.inflow_angle    = angle_pad_reg[CORDIC_PAD-1].phi;
    assign result.attack_angle    = angle_pad_reg[CORDIC_PAD-1].aoa;
    assign result.reverse_flow    = angle_pad_reg[CORDIC_PAD-1].rev;
    assign result.speed_magnitude = mag_out;
    assign result.mach_number     = mach_out;
    assign result.lift_force      = load_pad_reg[LOAD_PAD-1].lift;
    assign result.drag_force      = load_pad_reg[LOAD_PAD-1].drag;
    assign result.pitch_moment    = load_pad_reg[LOAD_PAD-1].moment;

endmodule

`default_nettype wire

/* rtl/core/bsal_cordic.sv */
// Inflow angle and angle of attack: pipelined CORDIC vectoring, one step per stage.
// Pipe depth is CORDIC_DEPTH stages; uses bsal_pkg.
`default_nettype none

module bsal_cordic import bsal_pkg::*; (
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [SPEED_W-1:0] tangent_speed,
    input  logic signed [SPEED_W-1:0] normal_speed,
    input  logic signed [ANGLE_W-1:0] pitch_angle,
    output logic signed [ANGLE_W-1:0] inflow_angle,
    output logic signed [ANGLE_W-1:0] attack_angle,
    output logic                      reverse_flow
);

    typedef struct packed {
        logic                      t_zero;
        logic                      n_neg;
        logic                      n_zero;
        logic                      rev;
        logic signed [ANGLE_W-1:0] pitch;
    } side_t;

    logic signed [SPEED_W:0]    t_abs;
    logic signed [SPEED_W:0]    n_sel;
    logic signed [CORDIC_W-1:0] x0_reg, y0_reg;
    side_t                      side0_reg;

    logic signed [CORDIC_W-1:0] x_reg [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] y_reg [CORDIC_STEPS];
    logic signed [ANGLE_W-1:0]  z_reg [CORDIC_STEPS];
    side_t                      side_reg [CORDIC_STEPS];

    logic signed [ANGLE_W-1:0]  phi_next, aoa_next;
    logic signed [ANGLE_W:0]    diff;
    logic signed [ANGLE_W-1:0]  phi_reg, aoa_reg;
    logic                       rev_reg;

    // start vector: x = |t|, y = -n mirrored into the right half plane
    assign t_abs = tangent_speed[SPEED_W-1] ? -(SPEED_W+1)'(tangent_speed)
                                            : (SPEED_W+1)'(tangent_speed);
    assign n_sel = tangent_speed[SPEED_W-1] ? (SPEED_W+1)'(normal_speed)
                                            : -(SPEED_W+1)'(normal_speed);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg           <= CORDIC_W'(t_abs) <<< CORDIC_PRE;
            y0_reg           <= CORDIC_W'(n_sel) <<< CORDIC_PRE;
            side0_reg.t_zero <= (tangent_speed == '0);
            side0_reg.n_neg  <= normal_speed[SPEED_W-1];
            side0_reg.n_zero <= (normal_speed == '0);
            side0_reg.rev    <= tangent_speed[SPEED_W-1];
            side0_reg.pitch  <= pitch_angle;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        logic signed [CORDIC_W-1:0] x_in, y_in, xs, ys;
        logic signed [ANGLE_W-1:0]  z_in;
        side_t                      s_in;

        if (i == 0)
        begin : g_first
            assign x_in = x0_reg;
            assign y_in = y0_reg;
            assign z_in = '0;
            assign s_in = side0_reg;
        end
        else
        begin : g_next
            assign x_in = x_reg[i-1];
            assign y_in = y_reg[i-1];
            assign z_in = z_reg[i-1];
            assign s_in = side_reg[i-1];
        end

        assign xs = x_in >>> i;
        assign ys = y_in >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_in > 0)
                begin
                    x_reg[i] <= x_in + ys;
                    y_reg[i] <= y_in - xs;
                    z_reg[i] <= z_in + ATAN_TAB[i];
                end
                else
                begin
                    x_reg[i] <= x_in - ys;
                    y_reg[i] <= y_in + xs;
                    z_reg[i] <= z_in - ATAN_TAB[i];
                end
                side_reg[i] <= s_in;
            end
        end
    end

    // zero tangent speed gives +-pi/2, or zero when the station is at rest
    always_comb
    begin
        priority if (side_reg[CORDIC_STEPS-1].t_zero)
        begin
            priority if (side_reg[CORDIC_STEPS-1].n_neg)
                phi_next = HALF_PI;
            else if (side_reg[CORDIC_STEPS-1].n_zero)
                phi_next = '0;
            else
                phi_next = -HALF_PI;
        end
        else if (z_reg[CORDIC_STEPS-1] > HALF_PI)
            phi_next = HALF_PI;
        else if (z_reg[CORDIC_STEPS-1] < -HALF_PI)
            phi_next = -HALF_PI;
        else
            phi_next = z_reg[CORDIC_STEPS-1];

        diff = (ANGLE_W+1)'(side_reg[CORDIC_STEPS-1].pitch) - (ANGLE_W+1)'(phi_next);
        priority if (diff[ANGLE_W] != diff[ANGLE_W-1])
            aoa_next = diff[ANGLE_W] ? {1'b1, {(ANGLE_W-1){1'b0}}}
                                     : {1'b0, {(ANGLE_W-1){1'b1}}};
        else
            aoa_next = diff[ANGLE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            phi_reg <= phi_next;
            aoa_reg <= aoa_next;
            rev_reg <= side_reg[CORDIC_STEPS-1].rev;
        end
    end

    assign inflow_angle = phi_reg;
    assign attack_angle = aoa_reg;
    assign reverse_flow = rev_reg;

endmodule

`default_nettype wire

/* rtl/core/bsal_magnitude.sv */
// Speed squared, bit-per-stage square root, and bit-per-stage Mach divider.
// Pipe depth is MAG_DEPTH stages; also exports speed squared at stage two. Uses bsal_pkg.
`default_nettype none

module bsal_magnitude import bsal_pkg::*; (
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [SPEED_W-1:0] tangent_speed,
    input  logic signed [SPEED_W-1:0] normal_speed,
    input  logic [SOUND_W-1:0]        sound_speed,
    output logic [VSQ_W-1:0]          vsq,
    output logic [CMAG_W-1:0]         speed_magnitude,
    output logic [CMAG_W-1:0]         mach_number
);

    logic signed [VSQ_W-1:0] sqt_full, sqn_full;
    logic [VSQ_W-1:0]        sqt_reg, sqn_reg, vsq_reg;

    logic [VSQ_W-1:0]        root_rem_reg [ROOT_STEPS];
    logic [VSQ_W-1:0]        root_res_reg [ROOT_STEPS];

    logic                    sat_reg;
    logic [CMAG_W-1:0]       mag_reg;

    logic [REM_W-1:0]        div_rem_reg [QUO_BITS];
    logic [QUO_BITS-1:0]     div_q_reg   [QUO_BITS];
    logic                    div_sat_reg [QUO_BITS];
    logic [CMAG_W-1:0]       div_mag_reg [QUO_BITS];

    assign sqt_full = tangent_speed * tangent_speed;
    assign sqn_full = normal_speed * normal_speed;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqt_reg <= sqt_full;
            sqn_reg <= sqn_full;
            vsq_reg <= sqt_reg + sqn_reg;
        end
    end

    assign vsq = vsq_reg;

    // floor square root, one result bit per stage
    for (genvar k = 0; k < ROOT_STEPS; k++)
    begin : g_root
        logic [VSQ_W-1:0] rem_in, res_in, bit_v, trial;

        if (k == 0)
        begin : g_first
            assign rem_in = vsq_reg;
            assign res_in = '0;
        end
        else
        begin : g_next
            assign rem_in = root_rem_reg[k-1];
            assign res_in = root_res_reg[k-1];
        end

        assign bit_v = VSQ_W'(1) << (VSQ_W - 2 - 2 * k);
        assign trial = res_in + bit_v;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_in >= trial)
                begin
                    root_rem_reg[k] <= rem_in - trial;
                    root_res_reg[k] <= (res_in >> 1) + bit_v;
                end
                else
                begin
                    root_rem_reg[k] <= rem_in;
                    root_res_reg[k] <= res_in >> 1;
                end
            end
        end
    end

    // quotient overflows 32 bits exactly when mag >= sound_speed * 2^8
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= root_res_reg[ROOT_STEPS-1][CMAG_W-1:0];
            sat_reg <= {8'b0, root_res_reg[ROOT_STEPS-1][CMAG_W-1:0]}
                       >= {sound_speed, 8'b0};
        end
    end

    // restoring division of mag * 2^24 by sound_speed, MSB first
    for (genvar j = 0; j < QUO_BITS; j++)
    begin : g_div
        logic [REM_W-1:0]    rem_in;
        logic [QUO_BITS-1:0] q_in;
        logic                sat_in;
        logic [CMAG_W-1:0]   mag_in;
        logic [VSQ_W-1:0]    sub;
        logic                hit;

        if (j == 0)
        begin : g_first
            assign rem_in = {mag_reg, {MACH_FRAC{1'b0}}};
            assign q_in   = '0;
            assign sat_in = sat_reg;
            assign mag_in = mag_reg;
        end
        else
        begin : g_next
            assign rem_in = div_rem_reg[j-1];
            assign q_in   = div_q_reg[j-1];
            assign sat_in = div_sat_reg[j-1];
            assign mag_in = div_mag_reg[j-1];
        end

        assign sub = VSQ_W'(sound_speed) << (QUO_BITS - 1 - j);
        assign hit = VSQ_W'(rem_in) >= sub;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_rem_reg[j] <= hit ? rem_in - sub[REM_W-1:0] : rem_in;
                div_q_reg[j]   <= {q_in[QUO_BITS-2:0], hit};
                div_sat_reg[j] <= sat_in;
                div_mag_reg[j] <= mag_in;
            end
        end
    end

    assign speed_magnitude = div_mag_reg[QUO_BITS-1];
    assign mach_number     = div_sat_reg[QUO_BITS-1] ? '1 : div_q_reg[QUO_BITS-1];

endmodule

`default_nettype wire

/* verif/bsal_tb_channels.sv */
`timescale 1ns / 100ps
// Testbench-side view of the request and result channels.
// Depends on nothing beyond bsal_pkg; the block's own interfaces are reused.
package bsal_tb_pkg;
    import bsal_pkg::*;

    typedef struct {
        logic signed [SPEED_W-1:0] tangent_speed;
        logic signed [SPEED_W-1:0] normal_speed;
        logic signed [ANGLE_W-1:0] pitch_angle;
        logic signed [COEFF_W-1:0] lift_coeff;
        logic signed [COEFF_W-1:0] drag_coeff;
        logic signed [COEFF_W-1:0] moment_coeff;
    } station_req_t;

    typedef struct {
        logic signed [ANGLE_W-1:0] inflow_angle;
        logic signed [ANGLE_W-1:0] attack_angle;
        logic                      reverse_flow;
        logic [CMAG_W-1:0]         speed_magnitude;
        logic [CMAG_W-1:0]         mach_number;
        logic signed [LOAD_W-1:0]  lift_force;
        logic signed [LOAD_W-1:0]  drag_force;
        logic signed [LOAD_W-1:0]  pitch_moment;
    } station_loads_t;
endpackage

/* verif/tb_blade_station_aero_loads.sv */
`timescale 1ns / 100ps
// Self-checking bench for blade_station_aero_loads: directed and random station
// requests under random stalls, checked against an in-bench load predictor.
// Depends on bsal_pkg, bsal_in_if, bsal_out_if and bsal_tb_pkg.
module tb_blade_station_aero_loads;
    import bsal_pkg::*;
    import bsal_tb_pkg::*;

    localparam int LATENCY    = 67;
    localparam int WATCH_MAX  = 20000;
    localparam int RANDOM_CNT = 850;

    int errors = 0;

    // one line per mismatch, counted
    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        errors++;
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    // Predicts the loads for each accepted request and checks results in order.
    class loads_scoreboard;
        logic [RHO_W-1:0]   rho;
        logic [SOUND_W-1:0] sound;
        logic [CHORD_W-1:0] chord;
        logic [AREA_W-1:0]  area;
        station_loads_t     pending[$];
        int                 checked;

        function new();
            rho = RHO_RESET; sound = SOUND_RESET; chord = CHORD_RESET; area = AREA_RESET;
            checked = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [31:0] val);
            case (idx)
                CFG_AIR_DENSITY:    rho = val[RHO_W-1:0];
                CFG_SOUND_SPEED:    sound = val;
                CFG_CHORD_LENGTH:   chord = val[CHORD_W-1:0];
                CFG_REFERENCE_AREA: area = val;
            endcase
        endfunction

        // CORDIC vectoring, floor shifts, arctangent table from the package
        function logic signed [ANGLE_W-1:0] inflow_of(longint t, longint n);
            longint x, y, z, xs, ys;
            z = 0;
            if (t == 0)
                return n < 0 ? HALF_PI : (n > 0 ? -HALF_PI : 0);
            x = (t < 0 ? -t : t) <<< 20;
            y = (t < 0 ? n : -n) * 64'sd1048576;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x += ys; y -= xs; z += ATAN_TAB[i];
                end else begin
                    x -= ys; y += xs; z -= ATAN_TAB[i];
                end
            end
            if (z > HALF_PI) z = HALF_PI;
            if (z < -longint'(HALF_PI)) z = -longint'(HALF_PI);
            return z[31:0];
        endfunction

        function logic [31:0] root_of(logic [63:0] v);
            logic [63:0] r;
            r = 0;
            for (int b = 31; b >= 0; b--)
                if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v)
                    r |= 64'd1 << b;
            return r[31:0];
        endfunction

        function logic signed [LOAD_W-1:0] load_of(logic signed [15:0] c, logic [63:0] vsq,
                                                   bit with_chord, int shift);
            logic [191:0] p, lim;
            bit           neg;
            neg = c < 0;
            p = neg ? 192'(-int'(c)) : 192'(int'(c));
            p = p * rho * area * vsq;
            if (with_chord) p = p * chord;
            p = p >> shift;
            lim = neg ? (192'd1 << 47) : ((192'd1 << 47) - 1);
            if (p > lim) p = lim;
            return neg ? -p[47:0] : p[47:0];
        endfunction

        function void note_request(station_req_t r);
            station_loads_t e;
            longint         t, n, aoa;
            logic [63:0]    vsq, mach;
            t = r.tangent_speed; n = r.normal_speed;
            vsq = 64'(t * t) + 64'(n * n);
            e.inflow_angle = inflow_of(t, n);
            aoa = longint'(r.pitch_angle) - longint'(e.inflow_angle);
            if (aoa > 64'sd2147483647) aoa = 64'sd2147483647;
            if (aoa < -64'sd2147483648) aoa = -64'sd2147483648;
            e.attack_angle = aoa[31:0];
            e.reverse_flow = t < 0;
            e.speed_magnitude = root_of(vsq);
            if (sound == 0) mach = 64'hFFFF_FFFF;
            else begin
                mach = (64'(e.speed_magnitude) << 24) / sound;
                if (mach > 64'hFFFF_FFFF) mach = 64'hFFFF_FFFF;
            end
            e.mach_number = mach[31:0];
            e.lift_force = load_of(r.lift_coeff, vsq, 0, FORCE_SHIFT);
            e.drag_force = load_of(r.drag_coeff, vsq, 0, FORCE_SHIFT);
            e.pitch_moment = load_of(r.moment_coeff, vsq, 1, MOMENT_SHIFT);
            pending.push_back(e);
        endfunction

        task check_result(station_loads_t g);
            station_loads_t e;
            if (pending.size() == 0) begin
                report("unexpected result", 0, 0);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (g.inflow_angle !== e.inflow_angle)
                report("inflow_angle", g.inflow_angle, e.inflow_angle);
            if (g.attack_angle !== e.attack_angle)
                report("attack_angle", g.attack_angle, e.attack_angle);
            if (g.reverse_flow !== e.reverse_flow)
                report("reverse_flow", g.reverse_flow, e.reverse_flow);
            if (g.speed_magnitude !== e.speed_magnitude)
                report("speed_magnitude", g.speed_magnitude, e.speed_magnitude);
            if (g.mach_number !== e.mach_number)
                report("mach_number", g.mach_number, e.mach_number);
            if (g.lift_force !== e.lift_force)
                report("lift_force", g.lift_force, e.lift_force);
            if (g.drag_force !== e.drag_force)
                report("drag_force", g.drag_force, e.drag_force);
            if (g.pitch_moment !== e.pitch_moment)
                report("pitch_moment", g.pitch_moment, e.pitch_moment);
        endtask
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_wr_en = 0;
    logic [1:0]  cfg_index = 0;
    logic [31:0] cfg_wr_data = 0;

    bsal_in_if  item();
    bsal_out_if result();

    blade_station_aero_loads dut (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
        .cfg_wr_data(cfg_wr_data), .item(item.sink), .result(result.source)
    );

    always #5 clk = ~clk;

    loads_scoreboard loads = new();

    // idling knobs: calm stretches turn random idling off on both sides
    bit calm_send = 0;
    bit calm_take = 0;
    bit hold_off  = 0;   // long receiver stall for back-pressure
    int sent      = 0;
    int quiet     = 0;

    initial
    begin
        item.valid = 0;
        item.tangent_speed = 0; item.normal_speed = 0; item.pitch_angle = 0;
        item.lift_coeff = 0; item.drag_coeff = 0; item.moment_coeff = 0;
        result.ready = 0;
    end

    // receiver: random stalls, plus the long hold-off
    always @(negedge clk)
    begin
        if (!rst_n || hold_off) result.ready <= 0;
        else result.ready <= calm_take ? 1'b1 : ($urandom_range(99) >= 12);
    end

    // checks at the rising edge; also the watchdog on accepted traffic
    always @(posedge clk)
    begin
        station_loads_t g;
        if (rst_n) begin
            if (result.valid && result.ready) begin
                g.inflow_angle = result.inflow_angle;
                g.attack_angle = result.attack_angle;
                g.reverse_flow = result.reverse_flow;
                g.speed_magnitude = result.speed_magnitude;
                g.mach_number = result.mach_number;
                g.lift_force = result.lift_force;
                g.drag_force = result.drag_force;
                g.pitch_moment = result.pitch_moment;
                loads.check_result(g);
            end
            if ((item.valid && item.ready) || (result.valid && result.ready)) quiet = 0;
            else quiet++;
            if (quiet >= WATCH_MAX) begin
                $display("watchdog: no traffic for %0d cycles", WATCH_MAX);
                $display("blade_station_aero_loads regression: fail");
                $finish;
            end
        end
    end

    // one request: random idle gap, then hold valid until accepted
    task automatic send_request(station_req_t r);
        while (!calm_send && $urandom_range(99) < 12) begin
            item.valid <= 0;
            @(negedge clk);
        end
        item.valid <= 1;
        item.tangent_speed <= r.tangent_speed;
        item.normal_speed <= r.normal_speed;
        item.pitch_angle <= r.pitch_angle;
        item.lift_coeff <= r.lift_coeff;
        item.drag_coeff <= r.drag_coeff;
        item.moment_coeff <= r.moment_coeff;
        do @(posedge clk); while (!item.ready);
        loads.note_request(r);
        sent++;
        @(negedge clk);
    endtask

    task automatic go_idle();
        item.valid <= 0;
        while (loads.pending.size() != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        cfg_wr_en <= 1; cfg_index <= idx; cfg_wr_data <= val;
        @(negedge clk);
        cfg_wr_en <= 0;
        loads.write_reg(idx, val);
    endtask

    function automatic station_req_t mk(int t, int n, int p, int cl, int cd, int cm);
        station_req_t r;
        r.tangent_speed = t; r.normal_speed = n; r.pitch_angle = p;
        r.lift_coeff = COEFF_W'(cl);
        r.drag_coeff = COEFF_W'(cd);
        r.moment_coeff = COEFF_W'(cm);
        return r;
    endfunction

    // realistic speeds in three of eight draws, a zero axis or full-range noise otherwise
    function automatic station_req_t random_req();
        station_req_t r;
        r = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        case ($urandom_range(7))
            0, 1, 2: begin
                r.tangent_speed = $signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000;
                r.normal_speed = $signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
            end
            3: r.tangent_speed = 0;
            4: r.normal_speed = 0;
            default: ;
        endcase
        return r;
    endfunction

    task automatic random_phase(int count);
        repeat (count) send_request(random_req());
    endtask

    initial
    begin
        int min_i, max_i;
        min_i = 32'h8000_0000;
        max_i = 32'h7FFF_FFFF;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: zero speed, each axis zero, extremes, reverse flow, coeff extremes
        send_request(mk(0, 0, 0, 0, 0, 0));
        send_request(mk(0, -65536, 1 << 28, 4096, 4096, 4096));
        send_request(mk(0, 65536, -(1 << 28), -4096, -4096, -4096));
        send_request(mk(65536 * 50, 0, 0, 32767, -32768, 32767));
        send_request(mk(-65536 * 50, 65536 * 3, 0, -32768, 32767, -32768));
        send_request(mk(min_i, min_i, min_i, -32768, -32768, -32768));
        send_request(mk(max_i, max_i, max_i, 32767, 32767, 32767));
        send_request(mk(min_i, max_i, max_i, 32767, -1, 1));
        send_request(mk(max_i, min_i, min_i, -1, 1, -1));
        send_request(mk(-1, 1, max_i, 1, 0, -1));
        send_request(mk(1, -1, min_i, 0, 1, 0));
        send_request(mk(65536, 65536, 0, 6000, 100, -300));
        send_request(mk(-65536, -65536, 0, 6000, 100, -300));
        go_idle();

        // setting extremes, each register written
        write_reg(CFG_AIR_DENSITY, 32'hF_FFFF);
        write_reg(CFG_SOUND_SPEED, 32'd1);
        write_reg(CFG_CHORD_LENGTH, 32'hFF_FFFF);
        write_reg(CFG_REFERENCE_AREA, 32'hFFFF_FFFF);
        random_phase(150);
        go_idle();

        write_reg(CFG_AIR_DENSITY, 32'd0);
        write_reg(CFG_SOUND_SPEED, 32'hFFFF_FFFF);
        write_reg(CFG_CHORD_LENGTH, 32'd0);
        write_reg(CFG_REFERENCE_AREA, 32'd0);
        random_phase(100);
        go_idle();

        // back to a typical setting; calm stretch then back-pressure
        write_reg(CFG_AIR_DENSITY, RHO_RESET);
        write_reg(CFG_SOUND_SPEED, SOUND_RESET);
        write_reg(CFG_CHORD_LENGTH, CHORD_RESET);
        write_reg(CFG_REFERENCE_AREA, AREA_RESET);
        calm_send = 1; calm_take = 1;
        random_phase(150);
        calm_send = 0; calm_take = 0;
        fork
            begin
                hold_off = 1;
                repeat (300) @(negedge clk);
                hold_off = 0;
            end
            random_phase(150);
        join
        go_idle();

        write_reg(CFG_AIR_DENSITY, $urandom_range(32'hF_FFFF));
        write_reg(CFG_SOUND_SPEED, $urandom_range(32'hFFFF_FFFF, 1));
        write_reg(CFG_CHORD_LENGTH, $urandom_range(32'hFF_FFFF));
        write_reg(CFG_REFERENCE_AREA, $urandom);
        random_phase(RANDOM_CNT - 550);
        go_idle();

        $display("covered %0d station requests, %0d results checked, over five settings",
                 sent, loads.checked);
        $display("including register extremes, zero speeds and a long result stall");
        if (errors == 0 && loads.pending.size() == 0)
            $display("blade_station_aero_loads regression: pass");
        else
            $display("blade_station_aero_loads regression: fail");
        $finish;
    end
endmodule

/* blade_station_aero_loads.f */
rtl/core/bsal_pkg.sv
rtl/core/bsal_in_if.sv
rtl/core/bsal_out_if.sv
rtl/core/bsal_cordic.sv
rtl/core/bsal_magnitude.sv
rtl/core/blade_station_aero_loads.sv
verif/bsal_tb_channels.sv
verif/tb_blade_station_aero_loads.sv
